// ----- rtl/fpebc_pkg.sv -----
`default_nettype none
package fpebc_pkg;
   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_TEST    = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   localparam int PLANE_COUNT = 6;
   localparam int PLANE_WORDS = 24;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_MREAD  = 10'b0000000010,
      ST_PLANE  = 10'b0000000100,
      ST_SQUARE = 10'b0000001000,
      ST_SQRT   = 10'b0000010000,
      ST_DIV    = 10'b0000100000,
      ST_STORE  = 10'b0001000000,
      ST_TREAD  = 10'b0010000000,
      ST_TACC   = 10'b0100000000,
      ST_RESULT = 10'b1000000000
   } state_type;
endpackage
`default_nettype wire

// ----- rtl/frustum_plane_extract_and_box_cull.sv -----
`default_nettype none
// Channel  Direction  Fields
// req      in         opcode, matrix_index, matrix_value, min_x..max_z
// rsp      out        visible
// A matrix write is stored in the matrix memory when it is accepted. A box test
// reads the 24 plane words from the plane memory, one word per cycle, then presents
// its result. Extraction reads the matrix memory, then per plane runs a 34-step
// square root and four (34 + FRAC_BITS)-step divisions. Reset is synchronous;
// planes read as zero until the first extraction through per-word valid bits.
// A waiting result holds the block; the next item is taken the cycle after it leaves.
module frustum_plane_extract_and_box_cull #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [3:0]  req_matrix_index,
   input  wire logic signed [31:0] req_matrix_value,
   input  wire logic signed [31:0] req_min_x,
   input  wire logic signed [31:0] req_min_y,
   input  wire logic signed [31:0] req_min_z,
   input  wire logic signed [31:0] req_max_x,
   input  wire logic signed [31:0] req_max_y,
   input  wire logic signed [31:0] req_max_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_visible
);
   localparam int QW = 34 + FRAC_BITS;

   fpebc_pkg::state_type state_ff;
   logic [31:0] mat_mem [16];
   logic [31:0] pl_mem [fpebc_pkg::PLANE_WORDS];
   logic [fpebc_pkg::PLANE_WORDS-1:0] pl_vld_ff;
   logic [31:0] mat_rd_ff, pl_rd_ff;
   logic [3:0]  mat_ra_ff;
   logic [4:0]  pl_ra_ff;
   logic signed [31:0] row_ff [16];
   logic [4:0]  cnt_ff;
   logic [2:0]  pid_ff;
   logic [1:0]  comp_ff;
   logic signed [32:0] pv_ff [4];
   logic [67:0] ssum_ff;
   logic [33:0] root_ff;
   logic [5:0]  bit_ff;
   logic [QW-1:0] quo_ff;
   logic [QW-1:0] dvd_ff;
   logic [34:0] rem_ff;
   logic [6:0]  step_ff;
   logic signed [31:0] res_ff [4];
   logic signed [31:0] box_lo_ff [3], box_hi_ff [3];
   logic signed [63:0] acc_ff;
   logic        vis_ff, rsp_valid_ff;

   function automatic logic [33:0] mag_first(input logic signed [32:0] v);
      logic [32:0] m;
      m = v[32] ? 33'(-v) : 33'(v);
      return {1'b0, m};
   endfunction

   logic accept;
   assign req_ready = (state_ff == fpebc_pkg::ST_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_visible = vis_ff;

   logic [31:0] pl_word;
   assign pl_word = pl_vld_ff[pl_ra_ff] ? pl_rd_ff : 32'd0;

   logic [32:0] mag_sel;
   logic signed [32:0] vsel;
   always_comb begin
      vsel = pv_ff[comp_ff];
      mag_sel = vsel[32] ? 33'(-vsel) : 33'(vsel);
   end

   logic [67:0] cand_sq;
   logic [33:0] cand;
   always_comb begin
      cand = root_ff | (34'd1 << bit_ff);
      cand_sq = 68'(cand) * 68'(cand);
   end

   logic [34:0] rem_sh;
   logic        rem_ge;
   always_comb begin
      rem_sh = {rem_ff[33:0], dvd_ff[QW-1]};
      rem_ge = rem_sh >= 35'(root_ff);
   end

   logic [QW-1:0] qfin;
   logic signed [31:0] sat_val;
   always_comb begin
      qfin = {quo_ff[QW-2:0], rem_ge};
      if (vsel[32]) begin
         sat_val = (qfin > QW'(33'h80000000)) ? 32'sh80000000 : 32'(-qfin);
      end else begin
         sat_val = (qfin > QW'(32'h7fffffff)) ? 32'sh7fffffff : 32'(qfin);
      end
   end

   logic signed [31:0] coef_w;
   logic signed [63:0] prod;
   assign coef_w = pl_word;
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: prod = 64'(coef_w) * 64'(coef_w > 0 ? box_hi_ff[0] : box_lo_ff[0]);
         2'd1: prod = 64'(coef_w) * 64'(coef_w > 0 ? box_hi_ff[1] : box_lo_ff[1]);
         2'd2: prod = 64'(coef_w) * 64'(coef_w > 0 ? box_hi_ff[2] : box_lo_ff[2]);
         default: prod = 64'(coef_w) <<< FRAC_BITS;
      endcase
   end

   logic [67:0] msq;
   assign msq = 68'(mag_sel) * 68'(mag_sel);

   logic pl_we;
   logic [4:0] pl_wa;
   assign pl_we = state_ff == fpebc_pkg::ST_STORE;
   assign pl_wa = 5'({pid_ff, 2'b00} + {3'd0, comp_ff});

   always_ff @(posedge clock) begin
      mat_rd_ff <= mat_mem[mat_ra_ff];
      pl_rd_ff <= pl_mem[pl_ra_ff];
      if (accept && fpebc_pkg::opcode_type'(req_opcode) == fpebc_pkg::OP_WRITE) begin
         mat_mem[req_matrix_index] <= req_matrix_value;
      end
      if (pl_we) begin
         pl_mem[pl_wa] <= (root_ff == 34'd0) ? 32'd0 : res_ff[comp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpebc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pl_vld_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            fpebc_pkg::ST_IDLE: begin
               cnt_ff <= '0;
               mat_ra_ff <= '0;
               pl_ra_ff <= '0;
               if (accept) begin
                  box_lo_ff[0] <= req_min_x; box_lo_ff[1] <= req_min_y;
                  box_lo_ff[2] <= req_min_z; box_hi_ff[0] <= req_max_x;
                  box_hi_ff[1] <= req_max_y; box_hi_ff[2] <= req_max_z;
                  acc_ff <= '0;
                  vis_ff <= 1'b1;
                  priority case (fpebc_pkg::opcode_type'(req_opcode))
                     fpebc_pkg::OP_EXTRACT: state_ff <= fpebc_pkg::ST_MREAD;
                     fpebc_pkg::OP_TEST:    state_ff <= fpebc_pkg::ST_TREAD;
                     default:               state_ff <= fpebc_pkg::ST_IDLE;
                  endcase
               end
            end
            fpebc_pkg::ST_MREAD: begin
               mat_ra_ff <= mat_ra_ff + 4'd1;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff != 5'd0) row_ff[4'(cnt_ff - 5'd1)] <= mat_rd_ff;
               if (cnt_ff == 5'd16) begin
                  pid_ff <= '0;
                  state_ff <= fpebc_pkg::ST_PLANE;
               end
            end
            fpebc_pkg::ST_PLANE: begin
               for (int k = 0; k < 4; k++) begin
                  unique case (pid_ff)
                     3'd0: pv_ff[k] <= 33'(row_ff[4*k+3]) + 33'(row_ff[4*k]);
                     3'd1: pv_ff[k] <= 33'(row_ff[4*k+3]) - 33'(row_ff[4*k]);
                     3'd2: pv_ff[k] <= 33'(row_ff[4*k+3]) + 33'(row_ff[4*k+1]);
                     3'd3: pv_ff[k] <= 33'(row_ff[4*k+3]) - 33'(row_ff[4*k+1]);
                     3'd4: pv_ff[k] <= 33'(row_ff[4*k+2]);
                     default: pv_ff[k] <= 33'(row_ff[4*k+3]) - 33'(row_ff[4*k+2]);
                  endcase
               end
               comp_ff <= '0;
               ssum_ff <= '0;
               state_ff <= fpebc_pkg::ST_SQUARE;
            end
            fpebc_pkg::ST_SQUARE: begin
               ssum_ff <= ssum_ff + msq;
               comp_ff <= comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  root_ff <= '0;
                  bit_ff <= 6'd33;
                  state_ff <= fpebc_pkg::ST_SQRT;
               end
            end
            fpebc_pkg::ST_SQRT: begin
               if (cand_sq <= ssum_ff) root_ff <= cand;
               bit_ff <= bit_ff - 6'd1;
               if (bit_ff == 6'd0) begin
                  comp_ff <= '0;
                  rem_ff <= '0;
                  quo_ff <= '0;
                  dvd_ff <= {mag_first(pv_ff[0]), {FRAC_BITS{1'b0}}};
                  step_ff <= '0;
                  state_ff <= fpebc_pkg::ST_DIV;
               end
            end
            fpebc_pkg::ST_DIV: begin
               if (root_ff == 34'd0) begin
                  state_ff <= fpebc_pkg::ST_STORE;
               end else begin
                  rem_ff <= rem_ge ? rem_sh - 35'(root_ff) : rem_sh;
                  quo_ff <= qfin;
                  dvd_ff <= dvd_ff << 1;
                  step_ff <= step_ff + 7'd1;
                  if (step_ff == 7'(QW - 1)) begin
                     res_ff[comp_ff] <= sat_val;
                     state_ff <= fpebc_pkg::ST_STORE;
                  end
               end
            end
            fpebc_pkg::ST_STORE: begin
               pl_vld_ff[pl_wa] <= 1'b1;
               comp_ff <= comp_ff + 2'd1;
               rem_ff <= '0;
               quo_ff <= '0;
               step_ff <= '0;
               dvd_ff <= {mag_first(pv_ff[2'(comp_ff + 2'd1)]), {FRAC_BITS{1'b0}}};
               if (comp_ff == 2'd3) begin
                  if (pid_ff == 3'(fpebc_pkg::PLANE_COUNT - 1)) begin
                     state_ff <= fpebc_pkg::ST_IDLE;
                  end else begin
                     pid_ff <= pid_ff + 3'd1;
                     state_ff <= fpebc_pkg::ST_PLANE;
                  end
               end else begin
                  state_ff <= fpebc_pkg::ST_DIV;
               end
            end
            fpebc_pkg::ST_TREAD: begin
               pl_ra_ff <= pl_ra_ff + 5'd1;
               state_ff <= fpebc_pkg::ST_TACC;
            end
            fpebc_pkg::ST_TACC: begin
               acc_ff <= (cnt_ff[1:0] == 2'd0) ? prod : acc_ff + prod;
               if (cnt_ff[1:0] == 2'd3 && (acc_ff + prod) < 0) vis_ff <= 1'b0;
               cnt_ff <= cnt_ff + 5'd1;
               if (pl_ra_ff != 5'(fpebc_pkg::PLANE_WORDS - 1)) begin
                  pl_ra_ff <= pl_ra_ff + 5'd1;
               end
               if (cnt_ff == 5'(fpebc_pkg::PLANE_WORDS - 1)) begin
                  state_ff <= fpebc_pkg::ST_RESULT;
               end
            end
            fpebc_pkg::ST_RESULT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= fpebc_pkg::ST_IDLE;
            end
            default: state_ff <= fpebc_pkg::ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
